// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset.
`define ASSERT_IFF(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IFF(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- rtl/sspr_pkg.sv -----
package sspr_pkg;

  // Period numerator and cap on the steps-per-revolution register
  localparam int unsigned PERIOD_NUMERATOR  = 30000;
  localparam int unsigned MAX_STEPS_PER_REV = 1023;

  // Field and datapath widths
  localparam int unsigned CFG_W  = 10;
  localparam int unsigned PER_W  = 15;
  localparam int unsigned PROD_W = 2 * CFG_W;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned TGT_W  = 11;
  localparam int unsigned GO_W   = 13;

  localparam logic [PER_W-1:0] NUMER     = PER_W'(PERIOD_NUMERATOR);
  localparam logic [CFG_W-1:0] SPR_RESET = CFG_W'(48);

  // Register indexes (address bit 2)
  localparam logic REG_SPEED = 1'b0;
  localparam logic REG_SPR   = 1'b1;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_MOVE    = 2'd1,
    KIND_GOTO    = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_APPLY = 4'b1000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic apply;
  } dp_cmd_t;

endpackage

// ----- rtl/sspr_ctrl.sv -----
module sspr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  sspr_pkg::kind_e   in_kind_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  logic              div_last_i,
  output sspr_pkg::dp_cmd_t cmd_o
);

  sspr_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  // Sequencing: capture, then multiply and divide for a move or go-to, then update
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      sspr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_kind_i inside {sspr_pkg::KIND_MOVE, sspr_pkg::KIND_GOTO}) begin
            state_d = sspr_pkg::ST_MUL;
          end else begin
            state_d = sspr_pkg::ST_APPLY;
          end
        end
      end
      sspr_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sspr_pkg::ST_DIV;
      end
      sspr_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_last_i) begin
          state_d = sspr_pkg::ST_APPLY;
        end
      end
      sspr_pkg::ST_APPLY: begin
        // wait for a free output slot
        if (!out_valid_q || out_ready_i) begin
          cmd_o.apply = 1'b1;
          out_valid_d = 1'b1;
          state_d     = sspr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sspr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sspr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/sspr_dp.sv -----
module sspr_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sspr_pkg::dp_cmd_t                 cmd_i,
  output logic                              div_last_o,
  input  logic [sspr_pkg::CFG_W-1:0]        speed_i,
  input  logic [sspr_pkg::CFG_W-1:0]        spr_i,
  input  sspr_pkg::kind_e                   kind_i,
  input  logic signed [sspr_pkg::STEP_W-1:0] steps_i,
  input  logic signed [sspr_pkg::TGT_W-1:0]  target_i,
  input  logic signed [1:0]                 pref_i,
  output logic [3:0]                        coils_o,
  output logic                              moving_o,
  output logic [sspr_pkg::CFG_W-1:0]        position_o
);

  localparam int unsigned CFG_W  = sspr_pkg::CFG_W;
  localparam int unsigned PER_W  = sspr_pkg::PER_W;
  localparam int unsigned PROD_W = sspr_pkg::PROD_W;
  localparam int unsigned CNT_W  = sspr_pkg::CNT_W;
  localparam int unsigned STEP_W = sspr_pkg::STEP_W;
  localparam int unsigned TGT_W  = sspr_pkg::TGT_W;
  localparam int unsigned GO_W   = sspr_pkg::GO_W;

  function automatic logic [3:0] coil_bit(input logic [1:0] ph);
    return 4'b0001 << ph;
  endfunction

  // Captured word
  sspr_pkg::kind_e            kind_q;
  logic signed [STEP_W-1:0]   steps_q;
  logic signed [TGT_W-1:0]    target_q;
  logic signed [1:0]          pref_q;

  // Period divider
  logic [PROD_W-1:0] prod_q, rem_q;
  logic [PER_W-1:0]  quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W:0]   trial;
  logic              trial_ge;

  // Motor state
  logic [3:0]                coils_q, coils_d;
  logic [1:0]                phase_q, phase_d;
  logic [CFG_W-1:0]          pos_q, pos_d;
  logic [STEP_W-1:0]         remain_q, remain_d;
  logic [1:0]                dir_q, dir_d;
  logic                      endless_q, endless_d;
  logic                      second_q, second_d;
  logic [PER_W-1:0]          period_q, period_d;
  logic [PER_W-1:0]          countdown_q, countdown_d;
  logic                      active_q, active_d;

  // Output word
  logic [3:0]       out_coils_q;
  logic             out_moving_q;
  logic [CFG_W-1:0] out_pos_q;

  // Effective steps per rev and derived values
  logic [CFG_W-1:0]        spr_eff;
  logic                    cfg_ok;
  logic [PER_W-1:0]        period_new;
  logic signed [GO_W-1:0]  spr_s, pos_s, tgt_s, half_s, diff, go_n;
  logic                    tgt_hi, tgt_lo;
  logic signed [STEP_W-1:0] move_n;
  logic [STEP_W-1:0]       rem_dec;
  logic [CFG_W:0]          pos_inc;

  assign spr_eff = ({{(32-CFG_W){1'b0}}, spr_i} > sspr_pkg::MAX_STEPS_PER_REV)
                   ? CFG_W'(sspr_pkg::MAX_STEPS_PER_REV) : spr_i;
  assign cfg_ok  = (speed_i != '0) && (spr_eff != '0);

  // Restoring divider step, one quotient bit a cycle
  assign trial      = {rem_q, sspr_pkg::NUMER[cnt_q]};
  assign trial_ge   = trial >= {1'b0, prod_q};
  assign div_last_o = (cnt_q == '0);
  assign period_new = (quo_q == '0) ? PER_W'(1) : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      steps_q  <= steps_i;
      target_q <= target_i;
      pref_q   <= pref_i;
    end
    if (cmd_i.mul) begin
      prod_q <= speed_i * spr_eff;
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= CNT_W'(PER_W - 1);
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? PROD_W'(trial - {1'b0, prod_q}) : trial[PROD_W-1:0];
      quo_q <= {quo_q[PER_W-2:0], trial_ge};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Go-to: step count toward the target
  always_comb begin
    spr_s  = $signed({{(GO_W-CFG_W){1'b0}}, spr_eff});
    pos_s  = $signed({{(GO_W-CFG_W){1'b0}}, pos_q});
    tgt_s  = GO_W'(target_q);
    half_s = $signed({{(GO_W-CFG_W+1){1'b0}}, spr_eff[CFG_W-1:1]});
    tgt_hi = tgt_s >= spr_s;
    tgt_lo = target_q[TGT_W-1];
    diff   = tgt_s - pos_s;
    if (pref_q == 2'sd1) begin
      go_n = (diff > 0) ? diff : diff + spr_s;
    end else if (pref_q[1]) begin
      go_n = (diff < 0) ? diff : diff - spr_s;
    end else if (diff > half_s) begin
      go_n = diff - spr_s;
    end else if (diff < -half_s) begin
      go_n = diff + spr_s;
    end else begin
      go_n = diff;
    end
    if (kind_q == sspr_pkg::KIND_MOVE) begin
      move_n = steps_q;
    end else if (tgt_hi) begin
      move_n = STEP_W'(1);
    end else if (tgt_lo) begin
      move_n = -STEP_W'(1);
    end else begin
      move_n = STEP_W'(go_n);
    end
  end

  // State update for one word
  always_comb begin
    coils_d     = coils_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    remain_d    = remain_q;
    dir_d       = dir_q;
    endless_d   = endless_q;
    second_d    = second_q;
    period_d    = period_q;
    countdown_d = countdown_q;
    active_d    = active_q;
    pos_inc     = {1'b0, pos_q} + 1'b1;
    rem_dec     = (!endless_q && remain_q != '0) ? remain_q - 1'b1 : remain_q;
    if (cmd_i.apply) begin
      case (kind_q)
        sspr_pkg::KIND_TICK: begin
          if (active_q) begin
            if (countdown_q > PER_W'(1)) begin
              countdown_d = countdown_q - 1'b1;
            end else if (second_q) begin
              // drop old coil, advance phase and position
              coils_d = coils_q & ~coil_bit(phase_q);
              phase_d = phase_q + dir_q;
              if (dir_q == 2'b01) begin
                pos_d = (pos_inc >= {1'b0, spr_eff}) ? '0 : pos_inc[CFG_W-1:0];
              end else if (dir_q[1]) begin
                if (pos_q == '0) begin
                  pos_d = (spr_eff == '0) ? '0 : spr_eff - 1'b1;
                end else begin
                  pos_d = pos_q - 1'b1;
                end
              end
              remain_d = rem_dec;
              if (rem_dec != '0) begin
                second_d    = 1'b0;
                countdown_d = period_q;
              end else begin
                active_d = 1'b0;
                coils_d  = '0;
              end
            end else begin
              // energize next coil
              coils_d     = coils_q | coil_bit(phase_q + dir_q);
              second_d    = 1'b1;
              countdown_d = period_q;
            end
          end
        end
        sspr_pkg::KIND_MOVE, sspr_pkg::KIND_GOTO: begin
          active_d = 1'b0;
          if (cfg_ok) begin
            period_d  = period_new;
            remain_d  = move_n[STEP_W-1] ? STEP_W'(-move_n) : STEP_W'(move_n);
            endless_d = 1'b0;
            if (move_n != '0) begin
              dir_d       = move_n[STEP_W-1] ? 2'b11 : 2'b01;
              coils_d     = coils_q | coil_bit(phase_q)
                            | coil_bit(phase_q + (move_n[STEP_W-1] ? 2'b11 : 2'b01));
              second_d    = 1'b1;
              countdown_d = period_new;
              active_d    = 1'b1;
            end else begin
              dir_d   = 2'b00;
              coils_d = '0;
            end
          end
          if (kind_q == sspr_pkg::KIND_GOTO && (tgt_hi || tgt_lo)) begin
            endless_d = 1'b1;
          end
        end
        default: begin
          active_d = 1'b0;
          coils_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coils_q     <= '0;
      phase_q     <= '0;
      pos_q       <= '0;
      remain_q    <= '0;
      dir_q       <= '0;
      endless_q   <= 1'b0;
      second_q    <= 1'b0;
      period_q    <= '0;
      countdown_q <= '0;
      active_q    <= 1'b0;
    end else begin
      coils_q     <= coils_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      remain_q    <= remain_d;
      dir_q       <= dir_d;
      endless_q   <= endless_d;
      second_q    <= second_d;
      period_q    <= period_d;
      countdown_q <= countdown_d;
      active_q    <= active_d;
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      out_coils_q  <= coils_d;
      out_moving_q <= active_d;
      out_pos_q    <= pos_d;
    end
  end

  assign coils_o    = out_coils_q;
  assign moving_o   = out_moving_q;
  assign position_o = out_pos_q;

endmodule

// ----- rtl/stepper_half_step_sequencer_top.sv -----
// Half-step sequencer for a four-coil stepper motor.
// Input stream: one word per tick or command. tuser carries the kind
// (tick, move by steps, go to position, release); tdata carries the step
// count, the target and the turn preference. Every input word yields one
// output word with the coil levels, the moving flag and the position.
// Configuration: APB registers speed (0x0) and steps_per_rev (0x4); write
// them only while no word is in flight. pready is always high.
// A tick or release is captured and then updates the state; a move or
// go-to is captured, then the speed * steps_per_rev multiply runs, then
// a shift-subtract divider forms the 15-bit half-step period, and then
// the state is updated.
// One word is in flight at a time; the next is accepted in the cycle after
// the update.
// The result sits in an output register: a stalled receiver only delays the
// update step of the following word, the input side still accepts it.
// Reset: coils off, position and phase zero, timing stopped, speed 0,
// steps_per_rev 48; no output word pending.
`include "assert_macros.svh"

module stepper_half_step_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] steps_signed, [26:16] target_step, [28:27] turn_preference, [31:29] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] coils, [4] moving, [14:5] position, [15] zero
  output logic [15:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CFG_W = sspr_pkg::CFG_W;

  logic [CFG_W-1:0]  speed_q, spr_q;
  logic              cfg_wr;
  sspr_pkg::dp_cmd_t cmd;
  logic              div_last;
  logic [3:0]        coils;
  logic              moving;
  logic [CFG_W-1:0]  position;
  sspr_pkg::kind_e   in_kind;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
      spr_q   <= sspr_pkg::SPR_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == sspr_pkg::REG_SPR) begin
        spr_q <= pwdata[CFG_W-1:0];
      end else begin
        speed_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == sspr_pkg::REG_SPR) ? {{(32-CFG_W){1'b0}}, spr_q}
                                                 : {{(32-CFG_W){1'b0}}, speed_q};

  assign in_kind = sspr_pkg::kind_e'(s_axis_tuser);

  sspr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (in_kind),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .div_last_i  (div_last),
    .cmd_o       (cmd)
  );

  sspr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .div_last_o (div_last),
    .speed_i    (speed_q),
    .spr_i      (spr_q),
    .kind_i     (in_kind),
    .steps_i    ($signed(s_axis_tdata[15:0])),
    .target_i   ($signed(s_axis_tdata[26:16])),
    .pref_i     ($signed(s_axis_tdata[28:27])),
    .coils_o    (coils),
    .moving_o   (moving),
    .position_o (position)
  );

  assign m_axis_tdata = {1'b0, position, moving, coils};

  // Checks
  `ASSERT_IFF(a_apply_slot_free, clk_i, rst_ni, cmd.apply |-> (!m_axis_tvalid || m_axis_tready))
  `ASSERT_IFF(a_moving_has_coil, clk_i, rst_ni, (m_axis_tvalid && moving) |-> (coils != 4'b0000))
  `ASSERT_IFF(a_one_in_flight, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `ASSERT_ALWAYS(a_no_load_in_div, clk_i, !(cmd.load && cmd.div_step))

endmodule
